// ===== rtl/core/fsta_pkg.sv =====
package fsta_pkg;

  // Table geometry and search limits
  localparam int SLOT_COUNT   = 512;
  localparam int FIT_WINDOW   = 16;
  localparam int RETRY_PASSES = 8;

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int WIN       = (FIT_WINDOW < SLOT_COUNT) ? FIT_WINDOW : SLOT_COUNT;
  localparam int RP_BITS   = $clog2(RETRY_PASSES + 1);
  localparam int DIVW      = 32 + SLOT_BITS;
  localparam int DCNT_BITS = $clog2(DIVW + 1);
  localparam int ENTRY_W   = 64;

  localparam logic [31:0] NEAR_FIT  = 32'd64;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  // Request codes
  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_GROW    = 3'd2;
  localparam logic [2:0] REQ_REALLOC = 3'd3;
  localparam logic [2:0] REQ_MERGE   = 3'd4;
  localparam logic [2:0] REQ_LONGEST = 3'd5;
  localparam logic [2:0] REQ_RELOAD  = 3'd6;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE  = 1'd1;

  localparam logic [31:0] HEAP_SIZE_RST = 32'd307200;

endpackage

// ===== rtl/core/fsta_req_if.sv =====
interface fsta_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] block_addr;
  logic [31:0] block_size;
  logic [31:0] new_size;

  modport source (output valid, req_type, block_addr, block_size, new_size, input ready);
  modport sink   (input valid, req_type, block_addr, block_size, new_size, output ready);
endinterface

// ===== rtl/core/fsta_res_if.sv =====
interface fsta_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== rtl/core/fsta_ram.sv =====
module fsta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first: a read at the address being written returns the new word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/free_space_table_allocator.sv =====
// Walks: each slot read state is followed by an evaluate state; the bubble search adds a check state.
// Alloc: best fit over the first WIN slots, taken at once on a near fit, then first fit over
// the rest, then up to RETRY_PASSES merge passes; a swap or join in a pass adds a second write.
// Free: an index divide, a probe for an empty slot, then up to SLOT_COUNT bubble passes.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: a clearing pass zeroes all SLOT_COUNT slots, not ready meanwhile.
module free_space_table_allocator (
  input  logic                           clk,
  input  logic                           rst,
  fsta_req_if.sink                       req,
  fsta_res_if.source                     res,
  input  logic                           cfg_we,
  input  logic [fsta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int SB = fsta_pkg::SLOT_BITS;
  localparam logic [SB-1:0] LAST = SB'(fsta_pkg::SLOT_COUNT - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FIN, S_W2,
    S_AW_RD, S_AW_EV, S_AF_RD, S_AF_EV, S_TK_RD, S_TK_EV,
    S_GR_RD, S_GR_EV,
    S_MP_START, S_MP_RD, S_MP_EV, S_MP_END,
    S_FR_START, S_DIV, S_DV_END, S_FS_RD, S_FS_EV, S_FWRITE,
    S_SR_START, S_SR_RD0, S_SR_EV0, S_SR_CHK, S_SR_RD, S_SR_EV,
    S_MN_START, S_MN_RD, S_MN_EV
  } state_t;

  state_t state, ret_state;

  logic [31:0] heap_start, heap_size;
  logic [2:0]  op;
  logic        reload;
  logic [SB-1:0] idx, best, prev_idx, target, sp_cnt;
  logic [31:0] amt, key, res_val, bestdiff;
  logic        res_stat, found, retry;
  logic [fsta_pkg::RP_BITS-1:0] rp_cnt;
  logic [31:0] f_addr, f_size;
  logic        prev_valid, any, moved;
  logic [31:0] p_addr, p_size, maxv, cur_a, cur_s, minv;
  logic [fsta_pkg::DIVW-1:0] dv, q;
  logic [31:0] rem;
  logic [fsta_pkg::DCNT_BITS-1:0] dcnt;
  logic        wr_en;
  logic [SB-1:0] wr_addr, sec_addr;
  logic [fsta_pkg::ENTRY_W-1:0] wr_data, sec_data, rdata;
  logic        out_valid, out_stat;
  logic [31:0] out_val;

  fsta_ram #(.WIDTH(fsta_pkg::ENTRY_W), .DEPTH(fsta_pkg::SLOT_COUNT)) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(idx),
    .rdata(rdata)
  );

  // Slot read fields
  logic [31:0] rd_a, rd_s;
  logic        idx_last;
  assign rd_a = rdata[63:32];
  assign rd_s = rdata[31:0];
  assign idx_last = (idx == LAST);

  // Fit tests and take-from-front
  logic        fits, better, near;
  logic [31:0] diff, tk_size, tk_addr;
  assign fits    = rd_s >= amt;
  assign diff    = rd_s - amt;
  assign better  = fits && (diff < bestdiff);
  assign near    = (diff < fsta_pkg::NEAR_FIT) || (diff < (amt >> 2));
  assign tk_size = rd_s - amt;
  assign tk_addr = (tk_size == 32'd0) ? 32'd0 : rd_a + amt;

  // Merge pass compare
  logic mp_swap, mp_join;
  assign mp_swap = rd_a < p_addr;
  assign mp_join = (p_size + p_addr) == rd_a;

  // Bubble search ordering
  logic        sr_swap, sr_join;
  logic [31:0] lo_a, lo_s, hi_a, hi_s;
  assign sr_swap = rd_a < cur_a;
  assign lo_a = sr_swap ? rd_a : cur_a;
  assign lo_s = sr_swap ? rd_s : cur_s;
  assign hi_a = sr_swap ? cur_a : rd_a;
  assign hi_s = sr_swap ? cur_s : rd_s;
  assign sr_join = hi_a == (lo_s + lo_a);

  // Restoring divide step
  logic [32:0] rem_sh;
  logic        dsub;
  assign rem_sh = {rem, dv[fsta_pkg::DIVW-1]};
  assign dsub   = rem_sh >= {1'b0, heap_size};

  assign req.ready        = (state == S_IDLE);
  assign res.valid        = out_valid;
  assign res.result_value = out_val;
  assign res.status       = out_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= 32'd0;
      heap_size  <= fsta_pkg::HEAP_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fsta_pkg::CFG_HEAP_START: heap_start <= cfg_data;
        fsta_pkg::CFG_HEAP_SIZE:  heap_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ret_state <= S_IDLE;
      idx       <= '0;
      reload    <= 1'b0;
      wr_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      if (out_valid && res.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        // Clearing sweep, slot 0 loaded from config on reload
        S_CLR: begin
          wr_en   <= 1'b1;
          wr_addr <= idx;
          wr_data <= (reload && idx == '0) ? {heap_start, heap_size} : '0;
          idx     <= idx + 1'b1;
          if (idx_last) begin
            state <= reload ? S_FIN : S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            op       <= req.req_type;
            res_val  <= 32'd0;
            res_stat <= fsta_pkg::ST_OK;
            idx      <= '0;
            case (req.req_type)
              fsta_pkg::REQ_ALLOC: begin
                amt      <= req.block_size;
                found    <= 1'b0;
                retry    <= 1'b0;
                bestdiff <= fsta_pkg::ALL_ONES;
                state    <= S_AW_RD;
              end
              fsta_pkg::REQ_FREE: begin
                f_addr <= req.block_addr;
                f_size <= req.block_size;
                state  <= S_FR_START;
              end
              fsta_pkg::REQ_GROW: begin
                key     <= req.block_addr;
                amt     <= req.block_size;
                res_val <= req.block_addr;
                state   <= S_GR_RD;
              end
              fsta_pkg::REQ_REALLOC: begin
                res_val <= 32'd1;
                if (req.new_size > req.block_size) begin
                  key   <= req.block_addr + req.block_size;
                  amt   <= req.new_size - req.block_size;
                  state <= S_GR_RD;
                end else if (req.block_size > req.new_size) begin
                  f_addr <= req.block_addr + req.new_size;
                  f_size <= req.block_size - req.new_size;
                  state  <= S_FR_START;
                end else begin
                  state <= S_FIN;
                end
              end
              fsta_pkg::REQ_MERGE, fsta_pkg::REQ_LONGEST: begin
                state <= S_MP_START;
              end
              fsta_pkg::REQ_RELOAD: begin
                reload <= 1'b1;
                state  <= S_CLR;
              end
              default: begin
                res_stat <= fsta_pkg::ST_FAIL;
                state    <= S_FIN;
              end
            endcase
          end
        end

        // Result register; waits while an earlier result is untaken
        S_FIN: begin
          reload <= 1'b0;
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_val   <= res_val;
            out_stat  <= res_stat;
            state     <= S_IDLE;
          end
        end

        // Second write of a swap or join
        S_W2: begin
          wr_en   <= 1'b1;
          wr_addr <= sec_addr;
          wr_data <= sec_data;
          state   <= ret_state;
        end

        // Best fit over the window
        S_AW_RD: state <= S_AW_EV;
        S_AW_EV: begin
          if (better) begin
            bestdiff <= diff;
            best     <= idx;
            found    <= 1'b1;
          end
          if (better && near) begin
            idx   <= idx;
            state <= S_TK_RD;
          end else if (idx == SB'(fsta_pkg::WIN - 1)) begin
            if (better || found) begin
              idx   <= better ? idx : best;
              state <= S_TK_RD;
            end else if (fsta_pkg::WIN >= fsta_pkg::SLOT_COUNT) begin
              rp_cnt <= fsta_pkg::RP_BITS'(fsta_pkg::RETRY_PASSES);
              state  <= S_MP_START;
            end else begin
              idx   <= SB'(fsta_pkg::WIN);
              state <= S_AF_RD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_AW_RD;
          end
        end

        // First fit after the window, or over the table on retry
        S_AF_RD: state <= S_AF_EV;
        S_AF_EV: begin
          if (fits) begin
            state <= S_TK_RD;
          end else if (idx_last) begin
            if (retry) begin
              res_stat <= fsta_pkg::ST_FAIL;
              state    <= S_FIN;
            end else begin
              rp_cnt <= fsta_pkg::RP_BITS'(fsta_pkg::RETRY_PASSES);
              state  <= S_MP_START;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_AF_RD;
          end
        end

        // Take amt from the front of slot idx
        S_TK_RD: state <= S_TK_EV;
        S_TK_EV: begin
          res_val <= rd_a;
          wr_en   <= 1'b1;
          wr_addr <= idx;
          wr_data <= {tk_addr, tk_size};
          state   <= S_FIN;
        end

        // Grow in place: region starting exactly at key
        S_GR_RD: state <= S_GR_EV;
        S_GR_EV: begin
          if (rd_a == key && fits) begin
            wr_en   <= 1'b1;
            wr_addr <= idx;
            wr_data <= {tk_addr, tk_size};
            state   <= S_FIN;
          end else if (idx_last) begin
            res_val  <= 32'd0;
            res_stat <= fsta_pkg::ST_FAIL;
            state    <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_GR_RD;
          end
        end

        // Merge pass
        S_MP_START: begin
          idx        <= '0;
          prev_valid <= 1'b0;
          any        <= 1'b0;
          maxv       <= 32'd0;
          state      <= S_MP_RD;
        end
        S_MP_RD: state <= S_MP_EV;
        S_MP_EV: begin
          idx       <= idx + 1'b1;
          ret_state <= idx_last ? S_MP_END : S_MP_RD;
          state     <= idx_last ? S_MP_END : S_MP_RD;
          if (rd_s != 32'd0) begin
            if (rd_s > maxv) begin
              maxv <= rd_s;
            end
            if (!prev_valid) begin
              prev_valid <= 1'b1;
              prev_idx   <= idx;
              p_addr     <= rd_a;
              p_size     <= rd_s;
            end else if (mp_swap) begin
              wr_en    <= 1'b1;
              wr_addr  <= idx;
              wr_data  <= {p_addr, p_size};
              sec_addr <= prev_idx;
              sec_data <= {rd_a, rd_s};
              prev_idx <= idx;
              state    <= S_W2;
            end else if (mp_join) begin
              wr_en    <= 1'b1;
              wr_addr  <= prev_idx;
              wr_data  <= {p_addr, p_size + rd_s};
              sec_addr <= idx;
              sec_data <= '0;
              p_size   <= p_size + rd_s;
              any      <= 1'b1;
              state    <= S_W2;
            end else begin
              prev_idx <= idx;
              p_addr   <= rd_a;
              p_size   <= rd_s;
            end
          end
        end
        S_MP_END: begin
          case (op)
            fsta_pkg::REQ_MERGE: begin
              res_val <= {31'd0, any};
              state   <= S_FIN;
            end
            fsta_pkg::REQ_LONGEST: begin
              if (any) begin
                state <= S_MP_START;
              end else begin
                res_val <= maxv;
                state   <= S_FIN;
              end
            end
            default: begin
              if (rp_cnt == fsta_pkg::RP_BITS'(1)) begin
                retry <= 1'b1;
                idx   <= '0;
                state <= S_AF_RD;
              end else begin
                rp_cnt <= rp_cnt - 1'b1;
                state  <= S_MP_START;
              end
            end
          endcase
        end

        // Free: slot index = off*SLOT_COUNT/heap_size
        S_FR_START: begin
          dv   <= fsta_pkg::DIVW'(f_addr - heap_start)
                  * fsta_pkg::DIVW'(fsta_pkg::SLOT_COUNT);
          rem  <= 32'd0;
          dcnt <= '0;
          if (heap_size == 32'd0) begin
            idx   <= LAST;
            state <= S_FS_RD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= dsub ? 32'(rem_sh - {1'b0, heap_size}) : rem_sh[31:0];
          q    <= {q[fsta_pkg::DIVW-2:0], dsub};
          dv   <= dv << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == fsta_pkg::DCNT_BITS'(fsta_pkg::DIVW - 1)) begin
            state <= S_DV_END;
          end
        end
        S_DV_END: begin
          idx   <= (q >= fsta_pkg::DIVW'(fsta_pkg::SLOT_COUNT)) ? LAST : q[SB-1:0];
          state <= S_FS_RD;
        end
        S_FS_RD: state <= S_FS_EV;
        S_FS_EV: begin
          if (rd_s == 32'd0) begin
            target <= idx;
            state  <= S_FWRITE;
          end else if (idx_last) begin
            state <= S_SR_START;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FS_RD;
          end
        end
        S_FWRITE: begin
          wr_en   <= 1'b1;
          wr_addr <= target;
          wr_data <= {f_addr, f_size};
          state   <= S_FIN;
        end

        // Slot search: bubble passes, stop on empty slot or join
        S_SR_START: begin
          sp_cnt <= '0;
          idx    <= '0;
          state  <= S_SR_RD0;
        end
        S_SR_RD0: state <= S_SR_EV0;
        S_SR_EV0: begin
          cur_a <= rd_a;
          cur_s <= rd_s;
          moved <= 1'b0;
          state <= S_SR_CHK;
        end
        S_SR_CHK: begin
          if (cur_s == 32'd0) begin
            target <= idx;
            state  <= S_FWRITE;
          end else if (idx_last) begin
            if (!moved || sp_cnt == LAST) begin
              state <= S_MN_START;
            end else begin
              sp_cnt <= sp_cnt + 1'b1;
              idx    <= '0;
              state  <= S_SR_RD0;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_SR_RD: state <= S_SR_EV;
        S_SR_EV: begin
          if (sr_join) begin
            wr_en   <= 1'b1;
            wr_addr <= idx - 1'b1;
            wr_data <= {lo_a, lo_s + hi_s};
            target  <= idx;
            state   <= S_FWRITE;
          end else begin
            cur_a <= hi_a;
            cur_s <= hi_s;
            if (sr_swap) begin
              wr_en     <= 1'b1;
              wr_addr   <= idx - 1'b1;
              wr_data   <= {lo_a, lo_s};
              sec_addr  <= idx;
              sec_data  <= {hi_a, hi_s};
              moved     <= 1'b1;
              ret_state <= S_SR_CHK;
              state     <= S_W2;
            end else begin
              state <= S_SR_CHK;
            end
          end
        end

        // Smallest region is overwritten
        S_MN_START: begin
          minv  <= fsta_pkg::ALL_ONES;
          best  <= '0;
          idx   <= '0;
          state <= S_MN_RD;
        end
        S_MN_RD: state <= S_MN_EV;
        S_MN_EV: begin
          if (rd_s < minv) begin
            minv <= rd_s;
            best <= idx;
          end
          if (idx_last) begin
            target <= (rd_s < minv) ? idx : best;
            state  <= S_FWRITE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MN_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_wr_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr <= LAST))
    else $error("table write beyond last slot");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stat == fsta_pkg::ST_FAIL) |-> (out_val == 32'd0))
    else $error("failed result carries a value");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> (!req.ready && !out_valid))
    else $error("ready during clearing pass");

endmodule
